FILE: hw/rtl/sdff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdff_pkg
// Shared constants and types of the signed decimal field formatter.
// ----------------------------------------------------------------------------
package sdff_pkg;

  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_MAX_FIELD  = 63;

  // Field parameter widths are fixed by the conversion spec.
  localparam int FLD_W = 6;
  // Position / count width: holds any field length up to 64 characters.
  localparam int CNT_W = 7;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Per-item conversion controls that travel with the value down the pipe.
  typedef struct packed {
    logic             neg;
    logic [FLD_W-1:0] width;
    logic [FLD_W-1:0] prec;
    logic             has_prec;
    logic             left;
    logic             zpad;
  } fmt_flags_t;

endpackage : sdff_pkg
`default_nettype wire

FILE: hw/rtl/signed_decimal_field_formatter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter
// printf-style %d formatter: one signed value in, one ASCII character out per
// transfer, with tlast on the final character of each field.
// ----------------------------------------------------------------------------
// Path: the first character passes stage A, the double-dabble stages D,
//   stages B and C, the emitter and its output register.
// Throughput: one character per cycle while out_tready is high; the emitter
//   holds each field until its last character is taken, so it sets the item
//   rate, and new values move down the pipe while a field is emitted.
// Reset: synchronous, active low; clears all valid bits and the emitter.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter #(
  parameter int VALUE_BITS = sdff_pkg::DEF_VALUE_BITS,
  parameter int MAX_FIELD  = sdff_pkg::DEF_MAX_FIELD
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // in_tdata, low bit up: value[VALUE_BITS], field_width[6], precision[6],
  //   has_precision[1], left_justify[1], zero_pad[1], zero fill to bytes
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  input  wire logic [((VALUE_BITS+15+7)/8)*8-1:0]      in_tdata,
  // out_tdata: char_out[8]; out_tlast: last_char
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  output logic [7:0]                                   out_tdata,
  output logic                                         out_tlast
);
  import sdff_pkg::*;

  localparam int VB      = VALUE_BITS;
  // Decimal digits needed for a magnitude of up to 2**(VB-1).
  localparam int NDIG    = (VB * 30103) / 100000 + 1;
  localparam int BCD_W   = NDIG * 4;
  localparam int DIG_IW  = $clog2(NDIG);
  // Double-dabble runs four bit steps per pipeline stage.
  localparam int STEPS   = 4;
  localparam int ND_STG  = (VB + STEPS - 1) / STEPS;

  // --------------------------------------------------------------------------
  // Stage A: unpack, clamp width/precision, take the magnitude.
  // --------------------------------------------------------------------------
  logic [VB-1:0]     in_value;
  logic [FLD_W-1:0]  in_width, in_prec;
  fmt_flags_t        in_flg;
  logic [VB-1:0]     in_mag;

  logic              vld_a_r;
  logic [VB-1:0]     mag_a_r;
  fmt_flags_t        flg_a_r;
  logic              rdy_a;

  always_comb begin
    in_value = in_tdata[VB-1:0];
    in_width = in_tdata[VB+5:VB];
    in_prec  = in_tdata[VB+11:VB+6];
    in_flg.neg      = in_value[VB-1];
    in_flg.width    = (in_width > FLD_W'(MAX_FIELD)) ? FLD_W'(MAX_FIELD) : in_width;
    in_flg.prec     = (in_prec > FLD_W'(MAX_FIELD - 1)) ? FLD_W'(MAX_FIELD - 1) : in_prec;
    in_flg.has_prec = in_tdata[VB+12];
    in_flg.left     = in_tdata[VB+13];
    in_flg.zpad     = in_tdata[VB+14];
    // Two's complement negate; the most negative value maps onto 2**(VB-1).
    in_mag = in_flg.neg ? (~in_value + {{(VB-1){1'b0}}, 1'b1}) : in_value;
  end

  assign in_tready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (rdy_a) begin
      vld_a_r <= in_tvalid;
    end
    if (rdy_a && in_tvalid) begin
      mag_a_r <= in_mag;
      flg_a_r <= in_flg;
    end
  end

  // --------------------------------------------------------------------------
  // Stages D: binary to BCD, shift-and-add-3, STEPS bits per stage.
  // --------------------------------------------------------------------------
  logic [ND_STG-1:0] vld_d_r;
  logic [ND_STG-1:0] rdy_d;
  logic [BCD_W-1:0]  bcd_d_r [ND_STG];
  logic [VB-1:0]     bin_d_r [ND_STG];
  fmt_flags_t        flg_d_r [ND_STG];
  logic              rdy_b;

  assign rdy_a = !vld_a_r || rdy_d[0];

  for (genvar s = 0; s < ND_STG; s++) begin : g_dabble
    logic             src_vld;
    logic [BCD_W-1:0] src_bcd;
    logic [VB-1:0]    src_bin;
    fmt_flags_t       src_flg;
    logic [BCD_W-1:0] bcd_nxt;
    logic [VB-1:0]    bin_nxt;
    logic             dn_rdy;

    if (s == 0) begin : g_src_a
      assign src_vld = vld_a_r;
      assign src_bcd = '0;
      assign src_bin = mag_a_r;
      assign src_flg = flg_a_r;
    end else begin : g_src_d
      assign src_vld = vld_d_r[s-1];
      assign src_bcd = bcd_d_r[s-1];
      assign src_bin = bin_d_r[s-1];
      assign src_flg = flg_d_r[s-1];
    end

    if (s == ND_STG - 1) begin : g_rdy_last
      assign dn_rdy = rdy_b;
    end else begin : g_rdy_mid
      assign dn_rdy = rdy_d[s+1];
    end

    assign rdy_d[s] = !vld_d_r[s] || dn_rdy;

    always_comb begin
      bcd_nxt = src_bcd;
      bin_nxt = src_bin;
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < VB) begin
          for (int k = 0; k < NDIG; k++) begin
            if (bcd_nxt[k*4 +: 4] >= 4'd5) begin
              bcd_nxt[k*4 +: 4] = bcd_nxt[k*4 +: 4] + 4'd3;
            end
          end
          bcd_nxt = {bcd_nxt[BCD_W-2:0], bin_nxt[VB-1]};
          bin_nxt = {bin_nxt[VB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_d_r[s] <= 1'b0;
      end else if (rdy_d[s]) begin
        vld_d_r[s] <= src_vld;
      end
      if (rdy_d[s] && src_vld) begin
        bcd_d_r[s] <= bcd_nxt;
        bin_d_r[s] <= bin_nxt;
        flg_d_r[s] <= src_flg;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: significant digit count and digit count after precision.
  // --------------------------------------------------------------------------
  logic [BCD_W-1:0] bcd_l;
  fmt_flags_t       flg_l;
  logic [CNT_W-1:0] nd_nxt, ndig_nxt;

  logic             vld_b_r;
  logic [BCD_W-1:0] bcd_b_r;
  fmt_flags_t       flg_b_r;
  logic [CNT_W-1:0] nd_b_r, ndig_b_r;
  logic             rdy_c;

  assign bcd_l = bcd_d_r[ND_STG-1];
  assign flg_l = flg_d_r[ND_STG-1];
  assign rdy_b = !vld_b_r || rdy_c;

  always_comb begin
    nd_nxt = '0;
    for (int k = 0; k < NDIG; k++) begin
      if (bcd_l[k*4 +: 4] != 4'd0) begin
        nd_nxt = CNT_W'(k + 1);
      end
    end
    // Zero prints a single '0' unless a precision was given.
    if (nd_nxt == '0 && !flg_l.has_prec) begin
      nd_nxt = CNT_W'(1);
    end
    ndig_nxt = (flg_l.has_prec && CNT_W'(flg_l.prec) > nd_nxt) ? CNT_W'(flg_l.prec) : nd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (rdy_b) begin
      vld_b_r <= vld_d_r[ND_STG-1];
    end
    if (rdy_b && vld_d_r[ND_STG-1]) begin
      bcd_b_r  <= bcd_l;
      flg_b_r  <= flg_l;
      nd_b_r   <= nd_nxt;
      ndig_b_r <= ndig_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: field layout as position thresholds.
  //   [0,t1) spaces, [t1,t2) minus, [t2,t3) zeros, [t3,t4) digits,
  //   [t4,total) trailing spaces.
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] body, total_nxt, pad, lsp, zcnt;
  logic [CNT_W-1:0] t1_nxt, t2_nxt, t3_nxt, t4_nxt;
  logic             zmode;

  logic             vld_c_r;
  logic [BCD_W-1:0] bcd_c_r;
  logic [CNT_W-1:0] t1_c_r, t2_c_r, t3_c_r, t4_c_r, total_c_r;
  logic             rdy_e;

  assign rdy_c = !vld_c_r || rdy_e;

  always_comb begin
    body      = ndig_b_r + CNT_W'(flg_b_r.neg);
    total_nxt = (CNT_W'(flg_b_r.width) > body) ? CNT_W'(flg_b_r.width) : body;
    pad       = total_nxt - body;
    // Left justify beats zero pad; a precision turns zero pad off.
    zmode     = flg_b_r.zpad && !flg_b_r.has_prec && !flg_b_r.left;
    lsp       = (!flg_b_r.left && !zmode) ? pad : '0;
    zcnt      = (ndig_b_r - nd_b_r) + (zmode ? pad : '0);
    t1_nxt    = lsp;
    t2_nxt    = t1_nxt + CNT_W'(flg_b_r.neg);
    t3_nxt    = t2_nxt + zcnt;
    t4_nxt    = t3_nxt + nd_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else if (rdy_c) begin
      vld_c_r <= vld_b_r;
    end
    if (rdy_c && vld_b_r) begin
      bcd_c_r   <= bcd_b_r;
      t1_c_r    <= t1_nxt;
      t2_c_r    <= t2_nxt;
      t3_c_r    <= t3_nxt;
      t4_c_r    <= t4_nxt;
      total_c_r <= total_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Emitter: walks the field one position per cycle, when the output
  // register is free; an empty field is taken and dropped without a transfer.
  // --------------------------------------------------------------------------
  logic             busy_r;
  logic [CNT_W-1:0] pos_r;
  logic [CNT_W-1:0] t1_r, t2_r, t3_r, t4_r, total_r;
  logic [3:0]       dig_r [NDIG];

  logic             out_tvalid_r;
  logic [7:0]       out_tdata_r;
  logic             out_tlast_r;

  logic             out_free, step, at_last;
  logic [CNT_W-1:0] didx;
  logic [7:0]       ch_nxt;

  assign out_free = !out_tvalid_r || out_tready;
  assign step     = busy_r && out_free;
  assign at_last  = (pos_r == total_r - CNT_W'(1));
  assign rdy_e    = !busy_r || (step && at_last);

  always_comb begin
    didx = t4_r - CNT_W'(1) - pos_r;
    if (pos_r < t1_r) begin
      ch_nxt = CH_SPACE;
    end else if (pos_r < t2_r) begin
      ch_nxt = CH_MINUS;
    end else if (pos_r < t3_r) begin
      ch_nxt = CH_ZERO;
    end else if (pos_r < t4_r) begin
      ch_nxt = CH_ZERO + {4'd0, dig_r[didx[DIG_IW-1:0]]};
    end else begin
      ch_nxt = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (rdy_e) begin
        busy_r <= vld_c_r && (total_c_r != '0);
      end
      if (out_free) begin
        out_tvalid_r <= step;
      end
    end
    if (rdy_e && vld_c_r) begin
      pos_r   <= '0;
      t1_r    <= t1_c_r;
      t2_r    <= t2_c_r;
      t3_r    <= t3_c_r;
      t4_r    <= t4_c_r;
      total_r <= total_c_r;
      for (int k = 0; k < NDIG; k++) begin
        dig_r[k] <= bcd_c_r[k*4 +: 4];
      end
    end else if (step) begin
      pos_r <= pos_r + CNT_W'(1);
    end
    if (step) begin
      out_tdata_r <= ch_nxt;
      out_tlast_r <= at_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pos_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pos_r < total_r))
    else $error("emitter position ran past the field");

  a_layout_order: assert property (@(posedge clk) disable iff (!rst_n)
    vld_c_r |-> (t1_c_r <= t2_c_r && t2_c_r <= t3_c_r && t3_c_r <= t4_c_r
                 && t4_c_r <= total_c_r))
    else $error("field layout thresholds out of order");

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_c_r && rdy_e && total_c_r != '0) |=> (busy_r && pos_r == '0))
    else $error("emitter did not start a loaded field at position zero");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> ((out_tdata_r >= CH_ZERO && out_tdata_r <= CH_ZERO + 8'd9)
                      || out_tdata_r == CH_MINUS || out_tdata_r == CH_SPACE))
    else $error("character outside digit, minus and space");

endmodule : signed_decimal_field_formatter
`default_nettype wire
